@@ sv/escaped_frame_receiver_defines.svh @@
// assertion macros shared by the escaped frame receiver
`ifndef ESCAPED_FRAME_RECEIVER_DEFINES_SVH
`define ESCAPED_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define EFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define EFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/efr_pkg.sv @@
// types and constants of the escaped frame receiver
package efr_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE       = 2'd0,
    MODE_READING    = 2'd1,
    MODE_AFTER_CTRL = 2'd2
  } rx_mode_e;

  typedef enum logic [2:0] {
    ST_NONE      = 3'd0,
    ST_STORED    = 3'd1,
    ST_DROPPED   = 3'd2,
    ST_COMPLETE  = 3'd3,
    ST_ABANDONED = 3'd4
  } status_e;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] CFG_CONTROL_BYTE = 2'd0;
  localparam logic [1:0] CFG_END_BYTE     = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT_MS   = 2'd2;

  localparam logic [7:0]  CONTROL_BYTE_RST = 8'd125;
  localparam logic [7:0]  END_BYTE_RST     = 8'd126;
  localparam logic [31:0] TIMEOUT_MS_RST   = 32'd1000;

  typedef struct packed {
    logic [7:0]  control_byte;
    logic [7:0]  end_byte;
    logic [31:0] timeout_ms;
  } cfg_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] payload_byte;
    logic [7:0] position;
    logic [8:0] frame_length;
  } result_t;

endpackage

@@ sv/escaped_frame_receiver.sv @@
// escaped_frame_receiver: byte-stuffed frame deframer with millisecond timeout
//
// Input channel (in_valid_i / in_stall_o): one beat is either a received byte
// (operation_i = 0, rx_byte_i) or a millisecond tick (operation_i = 1).
// Output channel (out_valid_o / out_stall_i): every byte beat gives exactly one
// result beat (status, payload_byte, position, frame_length); ticks give none.
// A frame is control byte, payload with doubled control bytes, then control
// byte plus end byte. Payload bytes come out with their buffer position.
// A byte passes the input register, then the result register. Throughput: one
// beat per cycle unless the receiver stalls; the input register and the result
// register each hold one beat and the deframing state updates in a single pass.
// When the receiver stalls, the result register holds its beat and the input
// register keeps the next byte; ticks still drain since they have no result.
// Configuration (cfg_we_i, cfg_index_i, cfg_wdata_i) is written by the user only while
// idle; the block does not enforce it. Reset clears the mode to idle, the write position
// and the elapsed counter, and loads control byte 125, end byte 126 and a 1000 ms timeout.
`include "escaped_frame_receiver_defines.svh"

module escaped_frame_receiver #(
  parameter int unsigned BUFFER_SIZE = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [7:0]  payload_byte_o,
  output logic [7:0]  position_o,
  output logic [8:0]  frame_length_o
);

  localparam int unsigned PosW = $clog2(BUFFER_SIZE + 1);

  efr_pkg::cfg_t     cfg;
  logic              in_vld_q, in_vld_d;
  logic              in_op_q;
  logic [7:0]        in_byte_q;
  logic              out_vld_q, out_vld_d;
  efr_pkg::result_t  res_q, res_d;
  efr_pkg::rx_mode_e mode_q, mode_d;
  logic [PosW-1:0]   wpos_q, wpos_d;
  logic [31:0]       elapsed_q, elapsed_d;
  logic              in_accept;
  logic              advance;
  logic              out_free;

  efr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  efr_step #(
    .BUFFER_SIZE (BUFFER_SIZE)
  ) u_step (
    .op_i      (in_op_q),
    .byte_i    (in_byte_q),
    .cfg_i     (cfg),
    .mode_i    (mode_q),
    .wpos_i    (wpos_q),
    .elapsed_i (elapsed_q),
    .mode_o    (mode_d),
    .wpos_o    (wpos_d),
    .elapsed_o (elapsed_d),
    .res_o     (res_d)
  );

  // result slot is free when empty or its beat leaves this cycle
  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && ((in_op_q == efr_pkg::OP_TICK) || out_free);
  assign in_stall_o = in_vld_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_accept) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (advance && in_op_q == efr_pkg::OP_BYTE) begin
      out_vld_d = 1'b1;
    end else if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      mode_q    <= efr_pkg::MODE_IDLE;
      wpos_q    <= '0;
      elapsed_q <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (advance) begin
        mode_q    <= mode_d;
        wpos_q    <= wpos_d;
        elapsed_q <= elapsed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_op_q   <= operation_i;
      in_byte_q <= rx_byte_i;
    end
    if (advance && in_op_q == efr_pkg::OP_BYTE) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign status_o       = res_q.status;
  assign payload_byte_o = res_q.payload_byte;
  assign position_o     = res_q.position;
  assign frame_length_o = res_q.frame_length;

  `EFR_ASSERT_NEXT(a_byte_gives_result, advance && in_op_q == efr_pkg::OP_BYTE,
    out_valid_o, "byte beat did not produce a result")
  `EFR_ASSERT_NOW(a_payload_fields_zero,
    out_valid_o && res_q.status != efr_pkg::ST_STORED,
    payload_byte_o == 8'd0 && position_o == 8'd0, "payload fields set without store")
  `EFR_ASSERT_NEXT(a_complete_to_idle,
    advance && in_op_q == efr_pkg::OP_BYTE && res_d.status == efr_pkg::ST_COMPLETE,
    mode_q == efr_pkg::MODE_IDLE, "frame completed but mode not idle")
  `EFR_ASSERT_NOW(a_wpos_in_range, 1'b1, 32'(wpos_q) <= BUFFER_SIZE,
    "write position beyond buffer size")

endmodule

@@ sv/efr_cfg_regs.sv @@
// configuration registers of the escaped frame receiver
module efr_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [31:0]   cfg_wdata_i,
  output efr_pkg::cfg_t cfg_o
);

  efr_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        efr_pkg::CFG_CONTROL_BYTE: cfg_d.control_byte = cfg_wdata_i[7:0];
        efr_pkg::CFG_END_BYTE:     cfg_d.end_byte     = cfg_wdata_i[7:0];
        efr_pkg::CFG_TIMEOUT_MS:   cfg_d.timeout_ms   = cfg_wdata_i;
        default:                   cfg_d              = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.control_byte <= efr_pkg::CONTROL_BYTE_RST;
      cfg_q.end_byte     <= efr_pkg::END_BYTE_RST;
      cfg_q.timeout_ms   <= efr_pkg::TIMEOUT_MS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/efr_step.sv @@
// per-beat deframing logic: next state and result for one item
module efr_step #(
  parameter int unsigned BUFFER_SIZE = 256
) (
  input  logic                                 op_i,
  input  logic [7:0]                           byte_i,
  input  efr_pkg::cfg_t                        cfg_i,
  input  efr_pkg::rx_mode_e                    mode_i,
  input  logic [$clog2(BUFFER_SIZE+1)-1:0]     wpos_i,
  input  logic [31:0]                          elapsed_i,
  output efr_pkg::rx_mode_e                    mode_o,
  output logic [$clog2(BUFFER_SIZE+1)-1:0]     wpos_o,
  output logic [31:0]                          elapsed_o,
  output efr_pkg::result_t                     res_o
);

  localparam int unsigned PosW = $clog2(BUFFER_SIZE + 1);
  localparam logic [PosW-1:0] BufLimit = PosW'(BUFFER_SIZE);

  logic              timed_out;
  logic              is_ctrl;
  logic              is_end;
  logic              has_room;
  logic [31:0]       pos_ext;
  efr_pkg::rx_mode_e mode_eff;
  efr_pkg::result_t  store_res;

  assign timed_out = elapsed_i > cfg_i.timeout_ms;
  assign is_ctrl   = byte_i == cfg_i.control_byte;
  assign is_end    = byte_i == cfg_i.end_byte;
  assign has_room  = wpos_i < BufLimit;
  assign pos_ext   = 32'(wpos_i);
  assign mode_eff  = timed_out ? efr_pkg::MODE_IDLE : mode_i;

  // stored or dropped payload beat
  always_comb begin
    store_res = '0;
    if (has_room) begin
      store_res.status       = efr_pkg::ST_STORED;
      store_res.payload_byte = byte_i;
      store_res.position     = pos_ext[7:0];
    end else begin
      store_res.status = efr_pkg::ST_DROPPED;
    end
  end

  always_comb begin
    mode_o    = mode_i;
    wpos_o    = wpos_i;
    elapsed_o = elapsed_i;
    res_o     = '0;
    if (op_i == efr_pkg::OP_TICK) begin
      if (elapsed_i != '1) begin
        elapsed_o = elapsed_i + 32'd1;
      end
    end else begin
      if (timed_out && mode_i != efr_pkg::MODE_IDLE) begin
        res_o.status = efr_pkg::ST_ABANDONED;
      end
      mode_o = mode_eff;
      case (mode_eff)
        efr_pkg::MODE_READING: begin
          if (is_ctrl) begin
            mode_o = efr_pkg::MODE_AFTER_CTRL;
          end else begin
            res_o = store_res;
            if (has_room) wpos_o = wpos_i + PosW'(1);
          end
        end
        efr_pkg::MODE_AFTER_CTRL: begin
          if (is_ctrl) begin
            mode_o = efr_pkg::MODE_READING;
            res_o  = store_res;
            if (has_room) wpos_o = wpos_i + PosW'(1);
          end else if (is_end) begin
            mode_o             = efr_pkg::MODE_IDLE;
            res_o.status       = efr_pkg::ST_COMPLETE;
            res_o.frame_length = pos_ext[8:0];
          end else begin
            mode_o       = efr_pkg::MODE_IDLE;
            res_o.status = efr_pkg::ST_ABANDONED;
          end
        end
        default: begin
          // idle: only the control byte opens a frame
          mode_o = efr_pkg::MODE_IDLE;
          if (is_ctrl) begin
            mode_o    = efr_pkg::MODE_READING;
            wpos_o    = '0;
            elapsed_o = '0;
          end
        end
      endcase
    end
  end

endmodule
